// ===== rtl/tsct_pkg.sv =====
// Package for the Taylor-series sine/cosine/tangent block.
// Field widths, fixed-point constants and parameter defaults.
// No dependencies.
package tsct_pkg;

    localparam int MAX_TERMS_DEF = 8;
    localparam int FRAC_BITS_DEF = 30;

    localparam int ANGLE_W = 7;
    localparam int Q30_W   = 31;
    localparam int TAN_W   = 30;

    typedef logic [ANGLE_W-1:0] angle_t;
    typedef logic [Q30_W-1:0]   q30_t;
    typedef logic [TAN_W-1:0]   tan_t;

    localparam q30_t   THR_RESET       = 31'd1074;
    localparam q30_t   Q30_ONE         = 31'h4000_0000;
    localparam tan_t   TAN_MAX         = 30'h3FFF_FFFF;
    localparam angle_t MAX_ANGLE       = 7'd89;
    localparam logic [31:0] RAD_PER_DEG_Q32 = 32'd74961321;

endpackage

// ===== rtl/tsct_if.sv =====
// Valid/ready channel interfaces for the trig block.
// Depends on tsct_pkg.
interface tsct_in_if
    import tsct_pkg::*;
();
    logic   valid;
    logic   ready;
    angle_t angle_deg;

    modport source (output valid, output angle_deg, input ready);
    modport sink   (input valid, input angle_deg, output ready);
endinterface

interface tsct_out_if
    import tsct_pkg::*;
();
    logic valid;
    logic ready;
    q30_t sine_q30;
    q30_t cosine_q30;
    tan_t tangent_q24;

    modport source (output valid, output sine_q30, output cosine_q30, output tangent_q24,
                    input ready);
    modport sink   (input valid, input sine_q30, input cosine_q30, input tangent_q24,
                    output ready);
endinterface

// ===== rtl/taylor_sine_cosine_tangent.sv =====
// Top level: pipelined Taylor-series sine, cosine and tangent.
// Depends on tsct_pkg and the interfaces in tsct_if.sv.
//
// One item (a whole-degree angle, clamped to 0..89) enters per clock while
// the output is not stalled, and its result is offered at the end of a pipe
// of 34 + 3*(MAX_TERMS-1) register stages, listed below in order. Two
// stages form x and x^2. The term recurrence then takes three stages per
// term (multiply by x^2, reciprocal multiply for the 1/((n+1)(n+2)) factor,
// remainder fixup). One stage folds in the last term and clamps. The tangent
// divider takes one setup stage and one stage per quotient bit. Sine and
// cosine lanes run side by side. A series stops at the first term below
// stop_threshold (Q1.30, that term excluded), or after MAX_TERMS terms. Sums
// are clamped to 0..1.0 and the tangent is sine/cosine in Q6.24, rounded,
// saturating to 2^30-1 (also for zero cosine). The whole pipe advances
// together: when the output holds an item that is not taken, every stage
// holds and in_ch.ready drops.
// Write stop_threshold only while the pipe is empty.
module taylor_sine_cosine_tangent
    import tsct_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  q30_t       cfg_wr_data,
    tsct_in_if.sink    in_ch,
    tsct_out_if.source out_ch
);

    localparam int F     = FRAC_BITS;
    localparam int TW    = F + 1;          // term / x width
    localparam int XW    = F + 2;          // x^2 width
    localparam int PW    = F + 2;          // rounded product width
    localparam int VW    = F + 3;          // dividend width
    localparam int SW    = F + 3;          // signed sum width
    localparam int NSTEP = MAX_TERMS - 1;
    localparam int NUM_W = Q30_W + 24;
    localparam int CMP_W = Q30_W + TAN_W;
    localparam int NST   = 34 + 3 * NSTEP;
    localparam logic [TW-1:0] ONE_T = TW'(1) << F;

    // ---------------- control ----------------
    q30_t             stop_threshold_reg;
    logic [NST-1:0]   vld_reg;
    logic             adv;
    logic [TW-1:0]    thr;

    assign adv         = !vld_reg[NST-1] || out_ch.ready;
    assign in_ch.ready = adv;
    assign thr         = TW'(stop_threshold_reg >> (30 - F));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_threshold_reg <= THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            stop_threshold_reg <= cfg_wr_data;
        end
    end

    // valid bits shift with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_ch.valid};
        end
    end

    // ---------------- degrees to radians, x^2 ----------------
    angle_t          a_cl;
    logic [33:0]     xr;
    logic [TW-1:0]   x0_reg, x0_next, x1_reg;
    logic [2*TW-1:0] xx;
    logic [XW-1:0]   x2_1_reg, x2_next;

    assign a_cl    = (in_ch.angle_deg > MAX_ANGLE) ? MAX_ANGLE : in_ch.angle_deg;
    assign xr      = 34'(a_cl) * 34'(RAD_PER_DEG_Q32) + (34'd1 << (31 - F));
    assign x0_next = TW'(xr >> (32 - F));
    assign xx      = (2*TW)'(x0_reg) * (2*TW)'(x0_reg) + ((2*TW)'(1) << (F - 1));
    assign x2_next = XW'(xx >> F);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg   <= x0_next;
            x1_reg   <= x0_reg;
            x2_1_reg <= x2_next;
        end
    end

    // ---------------- term recurrence, lane 0 sine, lane 1 cosine ----------------
    logic [PW-1:0]        prod_reg  [1:NSTEP][0:1];
    logic signed [SW-1:0] sum1_reg  [1:NSTEP][0:1];
    logic                 done1_reg [1:NSTEP][0:1];
    logic [VW-1:0]        v_reg     [1:NSTEP][0:1];
    logic [VW-1:0]        q0_reg    [1:NSTEP][0:1];
    logic signed [SW-1:0] sum2_reg  [1:NSTEP][0:1];
    logic                 done2_reg [1:NSTEP][0:1];
    logic [TW-1:0]        term3_reg [1:NSTEP][0:1];
    logic signed [SW-1:0] sum3_reg  [1:NSTEP][0:1];
    logic                 done3_reg [1:NSTEP][0:1];
    logic [XW-1:0]        x2a_reg   [1:NSTEP-1];
    logic [XW-1:0]        x2b_reg   [1:NSTEP-1];
    logic [XW-1:0]        x2c_reg   [1:NSTEP-1];

    for (genvar k = 1; k <= NSTEP; k++)
    begin : g_step
        logic [XW-1:0] x2_in;

        if (k == 1)
        begin : g_x2_first
            assign x2_in = x2_1_reg;
        end
        else
        begin : g_x2_next
            assign x2_in = x2c_reg[k-1];
        end

        if (k < NSTEP)
        begin : g_x2_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    x2a_reg[k] <= x2_in;
                    x2b_reg[k] <= x2a_reg[k];
                    x2c_reg[k] <= x2b_reg[k];
                end
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            localparam int NN    = ((l == 0) ? 1 : 0) + 2 * (k - 1);
            localparam int DIV   = (NN + 1) * (NN + 2);
            localparam int HALF  = DIV / 2;
            localparam int FL    = $clog2(DIV + 1) - 1;
            localparam int SH    = VW + FL;
            localparam logic [63:0] RECIP = (64'd1 << SH) / DIV;

            logic [TW-1:0]        t_in;
            logic signed [SW-1:0] s_in;
            logic                 d_in;
            logic [TW+XW-1:0]     mp;
            logic [PW-1:0]        prod_next;
            logic [VW-1:0]        v_next;
            logic [2*VW:0]        rp;
            logic [VW-1:0]        r3;
            logic [TW-1:0]        term_next;

            if (k == 1)
            begin : g_first
                assign t_in = (l == 0) ? x1_reg : ONE_T;
                assign s_in = SW'(t_in);
                assign d_in = 1'b0;
            end
            else
            begin : g_next
                logic stop;
                // fold the previous step's term into the sum
                assign stop = done3_reg[k-1][l] || (term3_reg[k-1][l] < thr);
                assign d_in = stop;
                assign t_in = term3_reg[k-1][l];
                if (((k - 1) % 2) == 1)
                begin : g_sub
                    assign s_in = stop ? sum3_reg[k-1][l]
                                       : sum3_reg[k-1][l] - SW'(term3_reg[k-1][l]);
                end
                else
                begin : g_add
                    assign s_in = stop ? sum3_reg[k-1][l]
                                       : sum3_reg[k-1][l] + SW'(term3_reg[k-1][l]);
                end
            end

            assign mp        = (TW+XW)'(t_in) * (TW+XW)'(x2_in)
                             + ((TW+XW)'(1) << (F - 1));
            assign prod_next = PW'(mp >> F);
            // rounded divide by DIV: reciprocal estimate, then one fixup
            assign v_next    = VW'(prod_reg[k][l]) + VW'(HALF);
            assign rp        = (2*VW+1)'(v_next) * (2*VW+1)'(RECIP);
            assign r3        = v_reg[k][l] - VW'(q0_reg[k][l] * VW'(DIV));
            assign term_next = TW'(q0_reg[k][l] + VW'(r3 >= VW'(DIV)));

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    prod_reg[k][l]  <= prod_next;
                    sum1_reg[k][l]  <= s_in;
                    done1_reg[k][l] <= d_in;
                    v_reg[k][l]     <= v_next;
                    q0_reg[k][l]    <= VW'(rp >> SH);
                    sum2_reg[k][l]  <= sum1_reg[k][l];
                    done2_reg[k][l] <= done1_reg[k][l];
                    term3_reg[k][l] <= term_next;
                    sum3_reg[k][l]  <= sum2_reg[k][l];
                    done3_reg[k][l] <= done2_reg[k][l];
                end
            end
        end
    end

    // ---------------- last term, clamp, scale to Q1.30 ----------------
    q30_t q30_fin_reg [0:1];

    for (genvar l = 0; l < 2; l++)
    begin : g_fin
        logic                 stop;
        logic signed [SW-1:0] s_fin;
        logic [TW-1:0]        res;

        assign stop = done3_reg[NSTEP][l] || (term3_reg[NSTEP][l] < thr);
        if ((NSTEP % 2) == 1)
        begin : g_sub
            assign s_fin = stop ? sum3_reg[NSTEP][l]
                                : sum3_reg[NSTEP][l] - SW'(term3_reg[NSTEP][l]);
        end
        else
        begin : g_add
            assign s_fin = stop ? sum3_reg[NSTEP][l]
                                : sum3_reg[NSTEP][l] + SW'(term3_reg[NSTEP][l]);
        end

        always_comb
        begin
            priority if (s_fin[SW-1])
            begin
                res = '0;
            end
            else if (s_fin > $signed(SW'(ONE_T)))
            begin
                res = ONE_T;
            end
            else
            begin
                res = TW'(s_fin);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q30_fin_reg[l] <= Q30_W'(res) << (30 - F);
            end
        end
    end

    // ---------------- tangent: restoring divide, one quotient bit per stage ----------------
    q30_t             rem_reg [0:TAN_W];
    logic [TAN_W-1:0] low_reg [0:TAN_W];
    tan_t             quo_reg [0:TAN_W];
    logic             ovf_reg [0:TAN_W];
    q30_t             sd_reg  [0:TAN_W];
    q30_t             cd_reg  [0:TAN_W];

    logic [NUM_W-1:0] num;
    logic             ovf_next;

    // quotient fits 30 bits only when num < cosine << 30; zero cosine overflows too
    assign num      = (NUM_W'(q30_fin_reg[0]) << 24) + NUM_W'(q30_fin_reg[1] >> 1);
    assign ovf_next = CMP_W'(num) >= (CMP_W'(q30_fin_reg[1]) << TAN_W);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= Q30_W'(num[NUM_W-1:TAN_W]);
            low_reg[0] <= num[TAN_W-1:0];
            quo_reg[0] <= '0;
            ovf_reg[0] <= ovf_next;
            sd_reg[0]  <= q30_fin_reg[0];
            cd_reg[0]  <= q30_fin_reg[1];
        end
    end

    for (genvar i = 1; i <= TAN_W; i++)
    begin : g_div
        logic [Q30_W:0] r2;
        logic           ge;

        assign r2 = {rem_reg[i-1], low_reg[i-1][TAN_W-1]};
        assign ge = r2 >= {1'b0, cd_reg[i-1]};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i] <= ge ? Q30_W'(r2 - {1'b0, cd_reg[i-1]}) : Q30_W'(r2);
                low_reg[i] <= low_reg[i-1] << 1;
                quo_reg[i] <= {quo_reg[i-1][TAN_W-2:0], ge};
                ovf_reg[i] <= ovf_reg[i-1];
                sd_reg[i]  <= sd_reg[i-1];
                cd_reg[i]  <= cd_reg[i-1];
            end
        end
    end

    // ---------------- output ----------------
    assign out_ch.valid       = vld_reg[NST-1];
    assign out_ch.sine_q30    = sd_reg[TAN_W];
    assign out_ch.cosine_q30  = cd_reg[TAN_W];
    assign out_ch.tangent_q24 = ovf_reg[TAN_W] ? TAN_MAX : quo_reg[TAN_W];

`ifndef SYNTHESIS
    a_zero_cos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.cosine_q30 == '0) |-> out_ch.tangent_q24 == TAN_MAX)
        else $error("zero cosine without saturated tangent");

    a_sums_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.sine_q30 <= Q30_ONE) && (out_ch.cosine_q30 <= Q30_ONE))
        else $error("series sum above 1.0");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_fill_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !in_ch.valid |=> !vld_reg[0])
        else $error("item appeared without input");
`endif

endmodule
